// ===== design/ega_nearest_color_planar_packer_defines.svh =====
// ----------------------------------------------------------------------------
// EGA nearest-color planar packer: assertion macros
// Shared concurrent assertion forms, clocked on clk; one disabled in reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef EGA_NEAREST_COLOR_PLANAR_PACKER_DEFINES_SVH
`define EGA_NEAREST_COLOR_PLANAR_PACKER_DEFINES_SVH

// checked only outside reset
`define EGANCPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// checked on every edge, reset included
`define EGANCPP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

// ===== design/egancpp_pkg.sv =====
// ----------------------------------------------------------------------------
// EGA nearest-color planar packer: package
// Widths, EGA color table (as level codes), square table and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package egancpp_pkg;

	localparam int PALETTE_ENTRIES  = 256;
	localparam int PIXELS_PER_GROUP = 8;

	localparam int IDX_W      = 8;
	localparam int COLOR_W    = 8;
	localparam int MAP_AW     = $clog2(PALETTE_ENTRIES);
	localparam int EGA_W      = 4;
	localparam int NUM_EGA    = 16;
	localparam int PLANES     = 4;
	localparam int SQ_W       = 2 * COLOR_W;
	localparam int DIST_W     = SQ_W + 2;
	localparam int NUM_LEVELS = 4;
	localparam int LVL_W      = 2;
	localparam int MAP_BANKS  = PIXELS_PER_GROUP / 2;

	localparam int IN_DATA_W  = 4 * IDX_W + PIXELS_PER_GROUP * IDX_W;
	localparam int OUT_DATA_W = PLANES * PIXELS_PER_GROUP;

	typedef enum logic {
		MODE_PALETTE = 1'b0,
		MODE_PIXELS  = 1'b1
	} mode_t;

	typedef logic [EGA_W-1:0]  ega_idx_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] addr;
		ega_idx_t          data;
	} map_wr_t;

	// channel intensities used by the EGA colors
	localparam logic [0:NUM_LEVELS-1][COLOR_W-1:0] LEVEL_VAL = '{
		8'd0, 8'd85, 8'd170, 8'd255
	};

	// per EGA color: {red, green, blue} level codes
	localparam logic [0:NUM_EGA-1][3*LVL_W-1:0] EGA_LVL = '{
		6'b00_00_00, 6'b00_00_10, 6'b00_10_00, 6'b00_10_10,
		6'b10_00_00, 6'b10_00_10, 6'b10_01_00, 6'b10_10_10,
		6'b01_01_01, 6'b01_01_11, 6'b01_11_01, 6'b01_11_11,
		6'b11_01_01, 6'b11_01_11, 6'b11_11_01, 6'b11_11_11
	};

	typedef logic [(1 << COLOR_W)-1:0][SQ_W-1:0] sq_table_t;

	function automatic sq_table_t build_sq_table();
		sq_table_t t;
		for (int i = 0; i < (1 << COLOR_W); i++) begin
			t[i] = SQ_W'(i * i);
		end
		return t;
	endfunction

	localparam sq_table_t SQ_TABLE = build_sq_table();

	function automatic logic [COLOR_W-1:0] abs_diff(
		input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

// ===== design/egancpp_nearest.sv =====
// ----------------------------------------------------------------------------
// EGA nearest-color search
// Squared distance to all 16 EGA colors, registered argmin tree, map write.
// ----------------------------------------------------------------------------
`default_nettype none

module egancpp_nearest (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [egancpp_pkg::IDX_W-1:0]       idx,
	input  logic [egancpp_pkg::COLOR_W-1:0]     red,
	input  logic [egancpp_pkg::COLOR_W-1:0]     green,
	input  logic [egancpp_pkg::COLOR_W-1:0]     blue,
	output egancpp_pkg::map_wr_t                 map_wr,
	output logic                                 busy
);
	import egancpp_pkg::*;

	typedef struct packed {
		dist_t    dsq;
		ega_idx_t idx;
	} cand_t;

	// lower index sits on the left, so ties keep it
	function automatic cand_t pick(input cand_t lo, input cand_t hi);
		return (hi.dsq < lo.dsq) ? hi : lo;
	endfunction

	logic                 in_range;
	logic [SQ_W-1:0]      sq_r [NUM_LEVELS];
	logic [SQ_W-1:0]      sq_g [NUM_LEVELS];
	logic [SQ_W-1:0]      sq_b [NUM_LEVELS];
	dist_t                dist_c [NUM_EGA];

	logic                 valid_s2;
	logic [MAP_AW-1:0]    addr_s2;
	dist_t                dist_s2 [NUM_EGA];

	cand_t                c0 [NUM_EGA];
	cand_t                c1 [NUM_EGA/2];
	cand_t                c2 [NUM_EGA/4];

	logic                 valid_s3;
	logic [MAP_AW-1:0]    addr_s3;
	cand_t                c2_s3 [NUM_EGA/4];
	cand_t                c3 [NUM_EGA/8];
	cand_t                best;

	assign in_range = {1'b0, idx} < (IDX_W+1)'(PALETTE_ENTRIES);

	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			sq_r[l] = SQ_TABLE[abs_diff(red,   LEVEL_VAL[l])];
			sq_g[l] = SQ_TABLE[abs_diff(green, LEVEL_VAL[l])];
			sq_b[l] = SQ_TABLE[abs_diff(blue,  LEVEL_VAL[l])];
		end
		for (int j = 0; j < NUM_EGA; j++) begin
			dist_c[j] = DIST_W'(sq_r[EGA_LVL[j][3*LVL_W-1 -: LVL_W]])
			          + DIST_W'(sq_g[EGA_LVL[j][2*LVL_W-1 -: LVL_W]])
			          + DIST_W'(sq_b[EGA_LVL[j][LVL_W-1 -: LVL_W]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= load && in_range;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= idx[MAP_AW-1:0];
		dist_s2 <= dist_c;
		addr_s3 <= addr_s2;
		c2_s3   <= c2;
	end

	always_comb begin
		for (int j = 0; j < NUM_EGA; j++) begin
			c0[j] = '{dsq: dist_s2[j], idx: EGA_W'(j)};
		end
		for (int j = 0; j < NUM_EGA/2; j++) begin
			c1[j] = pick(c0[2*j], c0[2*j+1]);
		end
		for (int j = 0; j < NUM_EGA/4; j++) begin
			c2[j] = pick(c1[2*j], c1[2*j+1]);
		end
		for (int j = 0; j < NUM_EGA/8; j++) begin
			c3[j] = pick(c2_s3[2*j], c2_s3[2*j+1]);
		end
		best = pick(c3[0], c3[1]);
	end

	assign map_wr = '{en: valid_s3, addr: addr_s3, data: best.idx};
	assign busy   = valid_s2 || valid_s3;

endmodule

`default_nettype wire

// ===== design/egancpp_map.sv =====
// ----------------------------------------------------------------------------
// EGA index map
// Palette index to EGA index, banked copies with two read ports each so that
// a whole pixel group is looked up at once. Read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module egancpp_map (
	input  logic                                                       clk,
	input  egancpp_pkg::map_wr_t                                       map_wr,
	input  logic                                                       rd_en,
	input  logic [egancpp_pkg::PIXELS_PER_GROUP-1:0][egancpp_pkg::MAP_AW-1:0] rd_addr,
	output logic [egancpp_pkg::PIXELS_PER_GROUP-1:0][egancpp_pkg::EGA_W-1:0]  rd_data
);
	import egancpp_pkg::*;

	ega_idx_t mem [MAP_BANKS][PALETTE_ENTRIES];
	logic [PIXELS_PER_GROUP-1:0][EGA_W-1:0] rd_q;

	// every bank holds the same contents
	always_ff @(posedge clk) begin
		if (map_wr.en) begin
			for (int b = 0; b < MAP_BANKS; b++) begin
				mem[b][map_wr.addr] <= map_wr.data;
			end
		end
		if (rd_en) begin
			for (int k = 0; k < PIXELS_PER_GROUP; k++) begin
				rd_q[k] <= mem[k >> 1][rd_addr[k]];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== design/ega_nearest_color_planar_packer.sv =====
// ----------------------------------------------------------------------------
// EGA nearest-color planar packer
// Palette items load a nearest-EGA-color map; pixel items map eight palette
// indices and emit the four EGA bit-plane bytes.
// ----------------------------------------------------------------------------
//  channel  dir  tdata / tuser                                        tlast
//  s_*      in   tdata: entry_index, red, green, blue, pixel_group    -
//                tuser: mode (0 palette, 1 pixels)
//  m_*      out  tdata: plane0..plane3 bytes                          -
//
// One item per cycle unless a pixel group is held. A palette item goes via
// the input register and search stages s2, s3 to the map; a pixel group that
// follows a palette item waits in the input register until that write has
// landed. Pixels pass the input register, then the map read into the output
// register. arst_n clears the valid flags only; map contents are undefined
// until written. Output back-pressure holds the pixel in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module ega_nearest_color_planar_packer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
	// [95:32] pixel_group
	input  logic [egancpp_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] mode
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [7:0] plane0, [15:8] plane1, [23:16] plane2, [31:24] plane3
	output logic [egancpp_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import egancpp_pkg::*;

	localparam int GROUP_LSB = 4 * IDX_W;

	logic                                   valid_s1;
	mode_t                                  mode_s1;
	logic [IDX_W-1:0]                       idx_s1;
	logic [COLOR_W-1:0]                     red_s1;
	logic [COLOR_W-1:0]                     green_s1;
	logic [COLOR_W-1:0]                     blue_s1;
	logic [PIXELS_PER_GROUP*IDX_W-1:0]      group_s1;

	logic                                   load_pal;
	logic                                   pix_go;
	logic                                   adv_s1;
	logic                                   busy;
	map_wr_t                                map_wr;

	logic [PIXELS_PER_GROUP-1:0][MAP_AW-1:0] rd_addr;
	logic [PIXELS_PER_GROUP-1:0]             in_range_c;
	logic [PIXELS_PER_GROUP-1:0][EGA_W-1:0]  rd_data;

	logic                                   valid_s2;
	logic [PIXELS_PER_GROUP-1:0]            in_range_s2;
	logic [PLANES-1:0][PIXELS_PER_GROUP-1:0] planes;

	assign load_pal = valid_s1 && (mode_s1 == MODE_PALETTE);
	// hold pixels while a palette write is still in flight
	assign pix_go   = valid_s1 && (mode_s1 == MODE_PIXELS) && !busy
	               && (!valid_s2 || m_tready);
	assign adv_s1   = load_pal || pix_go;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (pix_go) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= mode_t'(s_tuser);
			idx_s1   <= s_tdata[IDX_W-1:0];
			red_s1   <= s_tdata[2*IDX_W-1 -: COLOR_W];
			green_s1 <= s_tdata[3*IDX_W-1 -: COLOR_W];
			blue_s1  <= s_tdata[4*IDX_W-1 -: COLOR_W];
			group_s1 <= s_tdata[GROUP_LSB +: PIXELS_PER_GROUP*IDX_W];
		end
		if (pix_go) begin
			in_range_s2 <= in_range_c;
		end
	end

	always_comb begin
		for (int k = 0; k < PIXELS_PER_GROUP; k++) begin
			rd_addr[k]    = group_s1[k*IDX_W +: MAP_AW];
			in_range_c[k] = {1'b0, group_s1[k*IDX_W +: IDX_W]}
			              < (IDX_W+1)'(PALETTE_ENTRIES);
		end
	end

	egancpp_nearest u_nearest (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load_pal),
		.idx    (idx_s1),
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.map_wr (map_wr),
		.busy   (busy)
	);

	egancpp_map u_map (
		.clk     (clk),
		.map_wr  (map_wr),
		.rd_en   (pix_go),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// pixel 0 lands in bit 7 of each plane
	always_comb begin
		for (int p = 0; p < PLANES; p++) begin
			for (int k = 0; k < PIXELS_PER_GROUP; k++) begin
				planes[p][PIXELS_PER_GROUP-1-k] = in_range_s2[k] && rd_data[k][p];
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = planes;

endmodule

`default_nettype wire

// ===== design/egancpp_checker.sv =====
// ----------------------------------------------------------------------------
// EGA nearest-color planar packer: port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ega_nearest_color_planar_packer_defines.svh"

module egancpp_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [egancpp_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                                  s_tuser,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [egancpp_pkg::OUT_DATA_W-1:0]    m_tdata
);

	logic in_fire;

	assign in_fire = s_tvalid && s_tready && (s_tdata != '0 || s_tuser || !s_tuser);

	`EGANCPP_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !m_tvalid, "m_tvalid high in reset")

	// a result needs an accepted item and two register stages
	`EGANCPP_ASSERT_ALWAYS(a_quiet_after_reset, (arst_n && !$past(arst_n)) |-> (!m_tvalid ##1 !m_tvalid), "result too soon after reset")

	`EGANCPP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output changed while stalled")

	// a rise of m_tvalid needs an accepted input behind it, or an input held by s_tready low
	`EGANCPP_ASSERT(a_out_has_source, ($rose(m_tvalid) && $past(arst_n, 2)) |-> ($past(in_fire, 2) || $past(!s_tready, 1) || $past(!s_tready, 2)), "result without a source item")

endmodule

bind ega_nearest_color_planar_packer egancpp_checker u_checker (.*);

`default_nettype wire

// ===== test/tb_ega_nearest_color_planar_packer.sv =====
// ----------------------------------------------------------------------------
// EGA nearest-color planar packer: testbench
// Loads palette entries and streams pixel groups, with random gaps on both
// sides and one long output stall. A model map of nearest EGA indices
// predicts the four plane bytes, and each output transaction is checked
// against them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ega_nearest_color_planar_packer;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W           = egancpp_pkg::IN_DATA_W;
	localparam int OUT_W          = egancpp_pkg::OUT_DATA_W;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 10;
	localparam int MAX_REPORTS    = 10;

	// {red, green, blue} per EGA index
	localparam logic [0:15][23:0] EGA_RGB = {
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	typedef logic [3:0][7:0] plane_set_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	egancpp_pkg::ega_idx_t ega_map_model [0:255];
	bit                    entry_loaded  [0:255];
	int                    loaded_list[$];
	int                    last_written;
	plane_set_t            pending_planes[$];

	int error_count;
	int max_wait;
	bit hold_output;

	ega_nearest_color_planar_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic egancpp_pkg::ega_idx_t nearest_ega_index(
		input logic [7:0] r,
		input logic [7:0] g,
		input logic [7:0] b
	);
		int best;
		int sq_dist;
		int dr;
		int dg;
		int db;
		egancpp_pkg::ega_idx_t best_idx;
		best = 32'h7FFFFFFF;
		best_idx = '0;
		for (int j = 0; j < 16; j++) begin
			dr = int'(EGA_RGB[j][23:16]) - int'(r);
			dg = int'(EGA_RGB[j][15:8]) - int'(g);
			db = int'(EGA_RGB[j][7:0]) - int'(b);
			sq_dist = dr * dr + dg * dg + db * db;
			// strict compare keeps the lowest index on a tie
			if (sq_dist < best) begin
				best = sq_dist;
				best_idx = 4'(j);
			end
		end
		return best_idx;
	endfunction

	function automatic plane_set_t pack_planes(input logic [63:0] group);
		plane_set_t planes;
		egancpp_pkg::ega_idx_t ega;
		planes = '0;
		for (int k = 0; k < 8; k++) begin
			ega = ega_map_model[group[8*k +: 8]];
			for (int p = 0; p < 4; p++) begin
				planes[p][7-k] = ega[p];
			end
		end
		return planes;
	endfunction

	task automatic apply_item(input egancpp_pkg::mode_t kind, input logic [IN_W-1:0] data);
		int idx;
		idx = int'(data[7:0]);
		if (kind == egancpp_pkg::MODE_PALETTE) begin
			ega_map_model[idx] = nearest_ega_index(data[15:8], data[23:16], data[31:24]);
			if (!entry_loaded[idx]) begin
				entry_loaded[idx] = 1'b1;
				loaded_list.push_back(idx);
			end
			last_written = idx;
		end else begin
			pending_planes.push_back(pack_planes(data[95:32]));
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic send_item(input egancpp_pkg::mode_t kind, input logic [IN_W-1:0] data);
		int gap;
		gap = $urandom_range(0, max_wait);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		apply_item(kind, data);
	endtask

	// unused pixel field carries noise
	task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
		send_item(egancpp_pkg::MODE_PALETTE,
			{$urandom(), $urandom(), rgb[7:0], rgb[15:8], rgb[23:16], idx});
	endtask

	// unused palette fields carry noise
	task automatic send_pixels(input logic [63:0] group);
		send_item(egancpp_pkg::MODE_PIXELS, {group, 32'($urandom())});
	endtask

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return 8'(85 * $urandom_range(0, 3));
			// near the midpoints between EGA levels
			2: return 8'(42 + 85 * $urandom_range(0, 2) + $urandom_range(0, 1));
			default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	function automatic logic [23:0] random_color();
		return {random_channel(), random_channel(), random_channel()};
	endfunction

	// pixels drawn only from loaded entries, often the newest one
	function automatic logic [63:0] loaded_group();
		logic [63:0] group;
		for (int k = 0; k < 8; k++) begin
			if ($urandom_range(0, 4) == 0)
				group[8*k +: 8] = 8'(last_written);
			else
				group[8*k +: 8] = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
		end
		return group;
	endfunction

	function automatic int random_wait_limit();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 14;
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_exact_colors();
		max_wait = 14;
		for (int j = 0; j < 16; j++) begin
			send_palette(8'(j), EGA_RGB[j]);
		end
		send_pixels(64'h07060504_03020100);
		send_pixels(64'h0F0E0D0C_0B0A0908);
	endtask

	task automatic test_ties();
		max_wait = 3;
		send_palette(8'd16, 24'h000055);	// black vs blue
		send_palette(8'd17, 24'h005500);	// black vs green
		send_palette(8'd18, 24'h550000);	// black vs red
		send_palette(8'd255, 24'h808080);
		send_pixels(64'hFFFF1112_10111210);
	endtask

	task automatic test_write_then_read();
		max_wait = 0;
		send_palette(8'd3, 24'hFFFF55);
		send_pixels(64'h03030303_03030303);
		send_palette(8'd3, 24'h0000AA);
		send_pixels(64'h0F03FF03_00031203);
	endtask

	task automatic test_full_palette();
		int order [256];
		int pick;
		int tmp;
		for (int i = 0; i < 256; i++) order[i] = i;
		for (int i = 255; i > 0; i--) begin
			pick = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[pick];
			order[pick] = tmp;
		end
		for (int i = 0; i < 256; i++) begin
			if (i % 50 == 0) max_wait = random_wait_limit();
			send_palette(8'(order[i]), random_color());
		end
		for (int i = 0; i < 100; i++) begin
			if (i % 50 == 0) max_wait = random_wait_limit();
			send_pixels(loaded_group());
		end
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 700; i++) begin
			if (i % 50 == 0) max_wait = random_wait_limit();
			if ($urandom_range(0, 9) < 3)
				send_palette(8'($urandom_range(0, 255)), random_color());
			else
				send_pixels(loaded_group());
		end
	endtask

	task automatic test_output_stall();
		max_wait = 0;
		hold_output = 1'b1;
		for (int i = 0; i < 24; i++) begin
			if (i % 6 == 5)
				send_palette(8'($urandom_range(0, 255)), random_color());
			else
				send_pixels(loaded_group());
		end
	endtask

	// ---------------------------------------------------------------- sink and checks

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) $display("%s", msg);
	endtask

	initial begin : output_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end
			stall = $urandom_range(0, max_wait);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	plane_set_t want_planes;
	plane_set_t got_planes;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_planes = m_tdata;
			if (pending_planes.size() == 0) begin
				note_error($sformatf("unexpected transaction: m_tdata %h", m_tdata));
			end else begin
				want_planes = pending_planes.pop_front();
				for (int p = 0; p < 4; p++) begin
					if (got_planes[p] !== want_planes[p])
						note_error($sformatf("plane%0d byte: expected %h, got %h",
							p, want_planes[p], got_planes[p]));
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL ega_nearest_color_planar_packer");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		s_tvalid    = 1'b0;
		s_tuser     = 1'b0;
		s_tdata     = '0;
		arst_n      = 1'b0;
		max_wait    = 0;
		hold_output = 1'b0;
		error_count = 0;
		last_written = 0;
		for (int i = 0; i < 256; i++) begin
			ega_map_model[i] = '0;
			entry_loaded[i]  = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_exact_colors();
		test_ties();
		test_write_then_read();
		test_full_palette();
		test_random_mix();
		test_output_stall();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_planes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("PASS ega_nearest_color_planar_packer");
		end else begin
			$display("FAIL ega_nearest_color_planar_packer");
		end
		$finish;
	end

endmodule

`default_nettype wire
